FILE: hw/rtl/ssc_pkg.sv
// shared types and pattern constants for the signature string scanner
package ssc_pkg;

	localparam int EOCD_LEN = 4;
	localparam int STR_LEN  = 29;

	// pattern byte i sits at bits [8*(len-1-i) +: 8], so the final byte is [7:0]
	localparam logic [8*EOCD_LEN-1:0] EOCD_SIG  = 32'h504B_0506;
	localparam logic [8*STR_LEN-1:0]  DYLIB_STR = "Payload/apps.app/sfbase.dylib";
	localparam logic [8*STR_LEN-1:0]  PLIST_STR = "Payload/apps.app/sfbase.plist";

	localparam int          DATA_W     = 32;
	localparam int          ADDR_W     = 3;
	localparam logic [2:0]  COUNT_MAX  = 3'd7;
	localparam logic [2:0]  COUNT_RST  = 3'd4;

	typedef enum logic {
		REG_REQ_COUNT = 1'b0,
		REG_NONE      = 1'b1
	} ssc_reg_t;

	typedef struct packed {
		logic eocd;
		logic dylib;
		logic plist;
	} ssc_hit_t;

endpackage

FILE: hw/rtl/ssc_if.sv
// stream interfaces for scanned bytes and per-file reports
interface ssc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ssc_out_if;
	logic       valid;
	logic       ready;
	logic       infected;
	logic [2:0] eocd_count;
	logic       dylib_found;
	logic       plist_found;

	modport source (output valid, output infected, output eocd_count,
		output dylib_found, output plist_found, input ready);
	modport sink (input valid, input infected, input eocd_count,
		input dylib_found, input plist_found, output ready);
endinterface

FILE: hw/rtl/signature_string_scanner.sv
// top level of the signature string scanner: window cell chain, counters, report and required-count register
// a report is registered and valid in the cycle after the final byte's transfer
// one byte per cycle while the byte input is not stalled, set by the shift through the cell chain
// a waiting report stalls the byte input until the cycle in which it is taken
// reset clears the window, count and flags; the required count resets to 4
module signature_string_scanner #(
	parameter int WINDOW_BYTES = 29
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ssc_in_if.sink                       scan_in,
	ssc_out_if.source                    report,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ssc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ssc_pkg::DATA_W-1:0]   pwdata,
	output logic [ssc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int HIST = WINDOW_BYTES - 1;

	logic [2:0]         req_q;
	logic [2:0]         count_q;
	logic               dylib_q;
	logic               plist_q;
	logic               out_valid_q;
	logic               infected_q;
	logic [2:0]         out_count_q;
	logic               out_dylib_q;
	logic               out_plist_q;

	logic               acc;
	logic               last;
	logic [7:0]         chain [HIST+1];
	logic [HIST-1:0]    eocd_v;
	logic [HIST-1:0]    dylib_v;
	logic [HIST-1:0]    plist_v;
	logic               eocd_match;
	logic               dylib_match;
	logic               plist_match;
	logic [2:0]         count_nx;
	logic               dylib_nx;
	logic               plist_nx;
	ssc_pkg::ssc_reg_t  reg_sel;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = ssc_pkg::ssc_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= ssc_pkg::COUNT_RST;
		end else if (psel && penable && pwrite && pready && reg_sel == ssc_pkg::REG_REQ_COUNT) begin
			req_q <= pwdata[2:0];
		end
	end

	always_comb begin
		unique case (reg_sel)
			ssc_pkg::REG_REQ_COUNT: prdata = {{(ssc_pkg::DATA_W-3){1'b0}}, req_q};
			default:                prdata = '0;
		endcase
	end

	// byte stream
	assign scan_in.ready = !out_valid_q || report.ready;
	assign acc           = scan_in.valid && scan_in.ready;
	assign last          = scan_in.last_byte;
	assign chain[0]      = scan_in.data_byte;

	genvar k;
	generate
		for (k = 0; k < HIST; k++) begin : g_cell
			ssc_pkg::ssc_hit_t h;
			ssc_cell #(.K(k)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (acc),
				.clear    (last),
				.byte_in  (chain[k]),
				.byte_out (chain[k+1]),
				.hit      (h)
			);
			assign eocd_v[k]  = h.eocd;
			assign dylib_v[k] = h.dylib;
			assign plist_v[k] = h.plist;
		end

		if (HIST >= ssc_pkg::EOCD_LEN - 1) begin : g_eocd_fit
			assign eocd_match = (chain[0] == ssc_pkg::EOCD_SIG[7:0]) && (&eocd_v);
		end else begin : g_eocd_short
			assign eocd_match = 1'b0;
		end
		if (HIST >= ssc_pkg::STR_LEN - 1) begin : g_str_fit
			assign dylib_match = (chain[0] == ssc_pkg::DYLIB_STR[7:0]) && (&dylib_v);
			assign plist_match = (chain[0] == ssc_pkg::PLIST_STR[7:0]) && (&plist_v);
		end else begin : g_str_short
			assign dylib_match = 1'b0;
			assign plist_match = 1'b0;
		end
	endgenerate

	assign count_nx = (eocd_match && count_q != ssc_pkg::COUNT_MAX) ? count_q + 3'd1 : count_q;
	assign dylib_nx = dylib_q || dylib_match;
	assign plist_nx = plist_q || plist_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dylib_q <= 1'b0;
			plist_q <= 1'b0;
		end else if (acc) begin
			if (last) begin
				count_q <= '0;
				dylib_q <= 1'b0;
				plist_q <= 1'b0;
			end else begin
				count_q <= count_nx;
				dylib_q <= dylib_nx;
				plist_q <= plist_nx;
			end
		end
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && last) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last) begin
			infected_q  <= (count_nx == req_q) && dylib_nx && plist_nx;
			out_count_q <= count_nx;
			out_dylib_q <= dylib_nx;
			out_plist_q <= plist_nx;
		end
	end

	assign report.valid       = out_valid_q;
	assign report.infected    = infected_q;
	assign report.eocd_count  = out_count_q;
	assign report.dylib_found = out_dylib_q;
	assign report.plist_found = out_plist_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |=> count_q == 3'd0 && !dylib_q && !plist_q)
		else $error("scan state not cleared after final byte");

	a_report_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |=> out_valid_q && out_count_q == $past(count_nx))
		else $error("report missing or wrong count after final byte");

	a_no_report_mid_file: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !last |=> !out_valid_q)
		else $error("report raised without a final byte");

	a_verdict_needs_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && infected_q |-> out_dylib_q && out_plist_q)
		else $error("positive verdict without both strings");

endmodule

FILE: hw/rtl/ssc_cell.sv
// one window cell: holds a past byte, passes it on and compares it to the patterns
module ssc_cell #(
	parameter int K = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic                clear,
	input  logic [7:0]          byte_in,
	output logic [7:0]          byte_out,
	output ssc_pkg::ssc_hit_t   hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			if (clear) begin
				byte_q <= '0;
			end else begin
				byte_q <= byte_in;
			end
		end
	end

	assign byte_out = byte_q;

	generate
		if (K < ssc_pkg::EOCD_LEN - 1) begin : g_eocd
			assign hit.eocd = (byte_q == ssc_pkg::EOCD_SIG[8*(K+1) +: 8]);
		end else begin : g_eocd_any
			assign hit.eocd = 1'b1;
		end
		if (K < ssc_pkg::STR_LEN - 1) begin : g_str
			assign hit.dylib = (byte_q == ssc_pkg::DYLIB_STR[8*(K+1) +: 8]);
			assign hit.plist = (byte_q == ssc_pkg::PLIST_STR[8*(K+1) +: 8]);
		end else begin : g_str_any
			assign hit.dylib = 1'b1;
			assign hit.plist = 1'b1;
		end
	endgenerate

endmodule

FILE: sim/tb_top.sv
// testbench for the signature string scanner: byte streams, per-file report checks, register phases
`timescale 1ns / 100ps

module tb_top;

	localparam int AW = ssc_pkg::ADDR_W;
	localparam int DW = ssc_pkg::DATA_W;
	localparam int STR_BYTES = 29;
	localparam int HIST = 28;
	localparam int PAT_W = 8 * STR_BYTES;
	localparam logic [31:0]      EOCD_PAT  = 32'h504B_0506;
	localparam logic [PAT_W-1:0] DYLIB_PAT = "Payload/apps.app/sfbase.dylib";
	localparam logic [PAT_W-1:0] PLIST_PAT = "Payload/apps.app/sfbase.plist";
	localparam logic [PAT_W-1:0] EOCD_WIDE = {{(PAT_W-32){1'b0}}, EOCD_PAT};
	localparam logic [AW-1:0]    REQ_ADDR  = AW'(4 * int'(ssc_pkg::REG_REQ_COUNT));

	typedef struct packed {
		logic       infected;
		logic [2:0] count;
		logic       dylib;
		logic       plist;
	} report_t;

	typedef enum logic [3:0] {
		SEG_ZERO, SEG_ONES, SEG_EOCD, SEG_DYLIB, SEG_PLIST,
		SEG_EOCD_CUT, SEG_EOCD_TAIL, SEG_DYLIB_CUT, SEG_MUTANT
	} seg_t;

	typedef struct packed {
		int      cfg;
		seg_t    kind;
		int      reps;
		bit      fin;
		bit      typed;
		report_t want;
	} row_t;

	localparam int N_ROWS = 21;
	localparam row_t DIRECTED [N_ROWS] = '{
		'{-1, SEG_ZERO,      1, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0}},
		'{-1, SEG_ONES,      1, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0}},
		'{-1, SEG_EOCD,      1, 1'b1, 1'b1, '{1'b0, 3'd1, 1'b0, 1'b0}},
		'{-1, SEG_EOCD,      4, 1'b0, 1'b0, '0},
		'{-1, SEG_DYLIB,     1, 1'b0, 1'b0, '0},
		'{-1, SEG_PLIST,     1, 1'b1, 1'b1, '{1'b1, 3'd4, 1'b1, 1'b1}},
		'{-1, SEG_EOCD_CUT,  1, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0}},
		'{-1, SEG_EOCD_TAIL, 1, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0}},
		'{-1, SEG_DYLIB_CUT, 1, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0}},
		'{-1, SEG_EOCD,      8, 1'b0, 1'b0, '0},
		'{-1, SEG_DYLIB,     1, 1'b0, 1'b0, '0},
		'{-1, SEG_PLIST,     1, 1'b1, 1'b1, '{1'b0, 3'd7, 1'b1, 1'b1}},
		'{-1, SEG_PLIST,     1, 1'b0, 1'b0, '0},
		'{-1, SEG_DYLIB,     1, 1'b0, 1'b0, '0},
		'{-1, SEG_EOCD,      3, 1'b1, 1'b1, '{1'b0, 3'd3, 1'b1, 1'b1}},
		'{7,  SEG_EOCD,      9, 1'b0, 1'b0, '0},
		'{-1, SEG_DYLIB,     1, 1'b0, 1'b0, '0},
		'{-1, SEG_PLIST,     1, 1'b1, 1'b1, '{1'b1, 3'd7, 1'b1, 1'b1}},
		'{0,  SEG_ZERO,      1, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0}},
		'{-1, SEG_PLIST,     1, 1'b0, 1'b0, '0},
		'{-1, SEG_DYLIB,     1, 1'b1, 1'b1, '{1'b1, 3'd0, 1'b1, 1'b1}}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AW-1:0] paddr;
	logic [DW-1:0] pwdata;
	logic [DW-1:0] prdata;
	logic pready;

	ssc_in_if  in_if ();
	ssc_out_if out_if ();

	signature_string_scanner dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan_in (in_if),
		.report  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// scanner state as the block should hold it
	logic [7:0] hist [HIST];
	logic [2:0] sig_count;
	logic [2:0] req_count;
	logic       dylib_seen;
	logic       plist_seen;

	report_t    pending_reports [$];
	logic [7:0] file_bytes [$];
	int         mismatches;
	bit         src_idle;
	bit         snk_idle;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void note_fail(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	function automatic void clear_scan();
		foreach (hist[k])
			hist[k] = 8'h00;
		sig_count  = 3'd0;
		dylib_seen = 1'b0;
		plist_seen = 1'b0;
	endfunction

	// pattern of len bytes completed by cur, first pattern byte at bits [8*(len-1) +: 8]
	function automatic bit completes(logic [PAT_W-1:0] pat, int len, logic [7:0] cur);
		if (cur != pat[7:0])
			return 1'b0;
		for (int k = 0; k < len - 1; k++) begin
			if (hist[k] != pat[8*(k+1) +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit scan_byte(logic [7:0] cur, logic fin, output report_t rep);
		if (completes(EOCD_WIDE, 4, cur) && sig_count != 3'd7)
			sig_count = sig_count + 3'd1;
		if (completes(DYLIB_PAT, STR_BYTES, cur))
			dylib_seen = 1'b1;
		if (completes(PLIST_PAT, STR_BYTES, cur))
			plist_seen = 1'b1;
		for (int k = HIST - 1; k > 0; k--)
			hist[k] = hist[k-1];
		hist[0] = cur;
		rep = '0;
		if (!fin)
			return 1'b0;
		rep.infected = (sig_count == req_count) && dylib_seen && plist_seen;
		rep.count    = sig_count;
		rep.dylib    = dylib_seen;
		rep.plist    = plist_seen;
		clear_scan();
		return 1'b1;
	endfunction

	function automatic void append_pat(logic [PAT_W-1:0] pat, int len, int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(pat[8*(len-1-i) +: 8]);
	endfunction

	function automatic void append_seg(seg_t kind);
		int idx;
		case (kind)
			SEG_ZERO:      file_bytes.push_back(8'h00);
			SEG_ONES:      file_bytes.push_back(8'hFF);
			SEG_EOCD:      append_pat(EOCD_WIDE, 4, 4);
			SEG_DYLIB:     append_pat(DYLIB_PAT, STR_BYTES, STR_BYTES);
			SEG_PLIST:     append_pat(PLIST_PAT, STR_BYTES, STR_BYTES);
			SEG_EOCD_CUT:  append_pat(EOCD_WIDE, 4, 3);
			SEG_EOCD_TAIL: file_bytes.push_back(EOCD_PAT[7:0]);
			SEG_DYLIB_CUT: append_pat(DYLIB_PAT, STR_BYTES, STR_BYTES - 1);
			SEG_MUTANT: begin
				append_pat($urandom_range(0, 1) ? DYLIB_PAT : PLIST_PAT, STR_BYTES, STR_BYTES);
				idx = file_bytes.size() - 1 - int'($urandom_range(0, STR_BYTES - 1));
				file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
			end
			default: file_bytes.push_back(8'h00);
		endcase
	endfunction

	// mostly files built around the required count, the rest short noise
	function automatic void build_file();
		seg_t segs [$];
		seg_t tmp;
		int   n_sig;
		int   j;
		file_bytes.delete();
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 4))
				0, 1:    n_sig = int'(req_count);
				2:       n_sig = (req_count == 3'd0) ? 0 : int'(req_count) - 1;
				3:       n_sig = int'(req_count) + 1;
				default: n_sig = int'($urandom_range(0, 9));
			endcase
			repeat (n_sig)
				segs.push_back(SEG_EOCD);
			if ($urandom_range(0, 99) < 85)
				segs.push_back(SEG_DYLIB);
			if ($urandom_range(0, 99) < 85)
				segs.push_back(SEG_PLIST);
			if ($urandom_range(0, 3) == 0)
				segs.push_back($urandom_range(0, 1) ? SEG_MUTANT :
					($urandom_range(0, 1) ? SEG_EOCD_CUT : SEG_DYLIB_CUT));
			for (int i = segs.size() - 1; i > 0; i--) begin
				j = int'($urandom_range(0, i));
				tmp = segs[i];
				segs[i] = segs[j];
				segs[j] = tmp;
			end
			foreach (segs[i]) begin
				repeat ($urandom_range(0, 3))
					file_bytes.push_back(8'($urandom_range(0, 255)));
				append_seg(segs[i]);
			end
		end else begin
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(0, 1))
					file_bytes.push_back(EOCD_PAT[8*int'($urandom_range(0, 3)) +: 8]);
				else
					file_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (file_bytes.size() == 0)
			file_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic send_byte(logic [7:0] b, logic fin);
		report_t rep;
		if (src_idle && $urandom_range(0, 5) == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
		in_if.valid     <= 1'b1;
		in_if.data_byte <= b;
		in_if.last_byte <= fin;
		do
			@(posedge clk);
		while (!in_if.ready);
		if (scan_byte(b, fin, rep))
			pending_reports.push_back(rep);
	endtask

	task automatic send_bytes(bit fin);
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], fin && (i == file_bytes.size() - 1));
	endtask

	task automatic reg_access(bit wr, logic [DW-1:0] wdata, output logic [DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REQ_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_required(logic [2:0] v);
		logic [DW-1:0] rd;
		in_if.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		reg_access(1'b1, DW'(v), rd);
		req_count = v;
		@(posedge clk);
		reg_access(1'b0, '0, rd);
		if (rd !== DW'(v))
			note_fail($sformatf("required count readback: expected %0d, got %0h", v, rd));
	endtask

	// report side: random stalls plus one long hold-off
	initial begin
		int      stall;
		int      hold;
		int      seen;
		bit      held;
		report_t got;
		report_t want;
		stall = 0;
		hold  = 0;
		seen  = 0;
		held  = 1'b0;
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_if.valid && out_if.ready) begin
					got = '{out_if.infected, out_if.eocd_count, out_if.dylib_found,
						out_if.plist_found};
					seen++;
					if (pending_reports.size() == 0) begin
						note_fail($sformatf({"report with none pending: ",
							"infected=%0b count=%0d dylib=%0b plist=%0b"},
							got.infected, got.count, got.dylib, got.plist));
					end else begin
						want = pending_reports.pop_front();
						if (got !== want)
							note_fail($sformatf({"report mismatch: expected infected=%0b ",
								"count=%0d dylib=%0b plist=%0b, got infected=%0b ",
								"count=%0d dylib=%0b plist=%0b"},
								want.infected, want.count, want.dylib, want.plist,
								got.infected, got.count, got.dylib, got.plist));
					end
				end
				if (!held && seen == 25) begin
					held = 1'b1;
					hold = 150;
				end
				if (hold > 0) begin
					hold--;
					out_if.ready <= 1'b0;
				end else if (stall > 0) begin
					stall--;
					out_if.ready <= 1'b0;
				end else if (snk_idle && $urandom_range(0, 7) == 0) begin
					stall = int'($urandom_range(1, 6)) - 1;
					out_if.ready <= 1'b0;
				end else begin
					out_if.ready <= 1'b1;
				end
			end
		end
	end

	// byte side and register phases
	initial begin
		logic [2:0] phase_req [5];
		int         phase_bytes;
		int         phase_files;
		arst_n          <= 1'b0;
		in_if.valid     <= 1'b0;
		in_if.data_byte <= 8'h00;
		in_if.last_byte <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		src_idle        <= 1'b1;
		snk_idle        <= 1'b1;
		mismatches = 0;
		req_count  = ssc_pkg::COUNT_RST;
		clear_scan();
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			if (DIRECTED[r].cfg >= 0)
				set_required(3'(DIRECTED[r].cfg));
			file_bytes.delete();
			repeat (DIRECTED[r].reps)
				append_seg(DIRECTED[r].kind);
			send_bytes(DIRECTED[r].fin);
			if (DIRECTED[r].typed)
				pending_reports[pending_reports.size() - 1] = DIRECTED[r].want;
		end

		phase_req = '{3'd1, 3'd6, 3'd7, 3'($urandom_range(0, 7)), 3'd5};
		for (int p = 0; p < 5; p++) begin
			set_required(phase_req[p]);
			src_idle <= (p < 4);
			snk_idle <= (p < 4);
			phase_bytes = 0;
			phase_files = 0;
			while (phase_bytes < 240 || phase_files < 6) begin
				build_file();
				phase_bytes += file_bytes.size();
				phase_files++;
				send_bytes(1'b1);
			end
		end

		in_if.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: signature_string_scanner.f
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_if.sv
hw/rtl/ssc_cell.sv
hw/rtl/signature_string_scanner.sv
sim/tb_top.sv
